@@ src/adt_pkg.sv @@
// ----------------------------------------------------------------------------
// adt_pkg: shared types and constants
// Widths, register codes and the controller/datapath interface of the
// decorrelation-time search.
// ----------------------------------------------------------------------------
package adt_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int ADDR_W      = 12;   // log2 of MAX_SAMPLES
  localparam int CNT_W       = 13;   // holds 0 .. MAX_SAMPLES
  localparam int SUM_W       = 29;
  localparam int SQ_W        = 44;
  localparam int ACC_W       = 44;   // lagged product sum
  localparam int MB_W        = 28;   // serial multiplier operand B
  localparam int STEP_W      = 5;
  localparam int MUL_STEPS   = 28;
  localparam int WIDE_W      = 96;   // exact comparison terms
  localparam int SSQ_W       = 2 * MB_W;
  localparam int NQ_W        = SQ_W + CNT_W;
  localparam int NN_W        = 2 * CNT_W - 1;
  localparam int THR_W       = 16;
  localparam int LAG_W       = 10;
  localparam int TIME_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINLAG = 2'd2;

  localparam logic [THR_W-1:0]  THR_RST    = 16'd3277;
  localparam logic [LAG_W-1:0]  MAXLAG_RST = 10'd99;
  localparam logic [TIME_W-1:0] MINLAG_RST = 11'd5;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_STORE,
    CMD_MUL_SSQ,
    CMD_MUL_NQ,
    CMD_MUL_NN,
    CMD_SETUP,
    CMD_SUM_START,
    CMD_MUL_T1,
    CMD_MUL_T2,
    CMD_MUL_R1,
    CMD_MUL_R2,
    CMD_DIFF,
    CMD_NEXT_LAG,
    CMD_RES_ZERO,
    CMD_RES_FOUND,
    CMD_RES_CAP,
    CMD_PUBLISH
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sum_done;
    logic var_zero;
    logic less;
    logic last_lag;
  } dp_stat_t;

endpackage

@@ src/adt_ram.sv @@
// ----------------------------------------------------------------------------
// adt_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module adt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/adt_dp.sv @@
// ----------------------------------------------------------------------------
// adt_dp: datapath
// Sample store, running sums, lag-product pipeline, serial multiplier,
// configuration registers and result registers.
// ----------------------------------------------------------------------------
module adt_dp
  import adt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [TIME_W-1:0]     res_time,
  output logic                  res_capped,
  output logic                  res_zero_var
);

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [LAG_W-1:0]  max_lag_r;
  logic [TIME_W-1:0] min_lag_r;

  // series state
  logic        [CNT_W-1:0] count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic        [SQ_W-1:0]  sq_r;

  // derived terms
  logic [SSQ_W-1:0]          ssq_r;
  logic [NQ_W-1:0]           nq_r;
  logic [NN_W-1:0]           nn_r;
  logic [NQ_W-1:0]           var_r;
  logic [LAG_W-1:0]          limit_r;
  logic [LAG_W-1:0]          k_r;
  logic signed [WIDE_W-1:0]  t1_r, t2_r, r1_r, rhs_r, num_r;

  // lag-sum pipeline
  logic                           sum_act_r, v1_r, v2_r, sum_done_r;
  logic [CNT_W-1:0]               i_r;
  logic signed [2*SAMPLE_W-1:0]   p_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic [SAMPLE_W-1:0]            rd_a, rd_b;

  // serial multiplier
  logic                      mul_busy_r, mul_done_r;
  logic [STEP_W-1:0]         mul_cnt_r;
  logic signed [WIDE_W-1:0]  mul_a_r, mul_p_r, mul_p_nxt;
  logic [MB_W-1:0]           mul_b_r;
  dp_cmd_t                   mul_dst_r;

  // results
  logic [TIME_W-1:0] cand_time_r, out_time_r;
  logic              cand_cap_r, cand_zv_r, out_cap_r, out_zv_r;

  logic                         store_en, issue, mul_start, sum_drained;
  logic signed [SAMPLE_W-1:0]   x;
  logic signed [2*SAMPLE_W-1:0] xsq;
  logic [MB_W-1:0]              smag;
  logic [CNT_W-1:0]             terms, n_m1, i_plus_k;
  logic [TIME_W-1:0]            cand;
  logic signed [WIDE_W-1:0]     mul_a_in;
  logic [MB_W-1:0]              mul_b_in;

  assign x        = $signed(sample);
  assign xsq      = x * x;
  assign store_en = (cmd == CMD_STORE) && (count_r < CNT_W'(MAX_SAMPLES));
  assign smag     = sum_r[SUM_W-1] ? MB_W'(-sum_r) : MB_W'(sum_r);
  assign terms    = count_r - CNT_W'(k_r);
  assign n_m1     = count_r - CNT_W'(1);
  assign issue    = sum_act_r && (i_r < terms);
  assign i_plus_k = i_r + CNT_W'(k_r);
  assign mul_start = (cmd == CMD_MUL_SSQ || cmd == CMD_MUL_NQ || cmd == CMD_MUL_NN ||
                      cmd == CMD_MUL_T1 || cmd == CMD_MUL_T2 || cmd == CMD_MUL_R1 ||
                      cmd == CMD_MUL_R2);
  assign sum_drained = sum_act_r && !issue && !v1_r && !v2_r;

  adt_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram_a (
    .clk(clk), .wr_en(store_en), .wr_addr(count_r[ADDR_W-1:0]), .wr_data(sample),
    .rd_addr(i_r[ADDR_W-1:0]), .rd_data(rd_a)
  );

  adt_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram_b (
    .clk(clk), .wr_en(store_en), .wr_addr(count_r[ADDR_W-1:0]), .wr_data(sample),
    .rd_addr(i_plus_k[ADDR_W-1:0]), .rd_data(rd_b)
  );

  always_comb begin
    mul_a_in = '0;
    mul_b_in = '0;
    case (cmd)
      CMD_MUL_SSQ: begin mul_a_in = WIDE_W'(smag);    mul_b_in = smag;              end
      CMD_MUL_NQ:  begin mul_a_in = WIDE_W'(sq_r);    mul_b_in = MB_W'(count_r);    end
      CMD_MUL_NN:  begin mul_a_in = WIDE_W'(count_r); mul_b_in = MB_W'(count_r);    end
      CMD_MUL_T1:  begin mul_a_in = WIDE_W'(acc_r);   mul_b_in = MB_W'(nn_r);       end
      CMD_MUL_T2:  begin mul_a_in = WIDE_W'(ssq_r);   mul_b_in = MB_W'(terms);      end
      CMD_MUL_R1:  begin mul_a_in = WIDE_W'(var_r);   mul_b_in = MB_W'(terms);      end
      CMD_MUL_R2:  begin mul_a_in = r1_r;             mul_b_in = MB_W'(thr_r);      end
      default:     begin mul_a_in = '0;               mul_b_in = '0;                end
    endcase
  end

  assign mul_p_nxt = mul_b_r[0] ? mul_p_r + mul_a_r : mul_p_r;

  always_comb begin
    case (cmd)
      CMD_RES_FOUND: cand = TIME_W'(k_r) + TIME_W'(1);
      CMD_RES_CAP:   cand = TIME_W'(limit_r) + TIME_W'(1);
      default:       cand = TIME_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RST;
      max_lag_r  <= MAXLAG_RST;
      min_lag_r  <= MINLAG_RST;
      count_r    <= '0;
      sum_r      <= '0;
      sq_r       <= '0;
      sum_act_r  <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      sum_done_r <= 1'b0;
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_cnt_r  <= '0;
      mul_dst_r  <= CMD_IDLE;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_THR:    thr_r     <= cfg_wdata[THR_W-1:0];
          CFG_MAXLAG: max_lag_r <= cfg_wdata[LAG_W-1:0];
          CFG_MINLAG: min_lag_r <= cfg_wdata[TIME_W-1:0];
          default:    ;
        endcase
      end

      if (store_en) begin
        count_r <= count_r + CNT_W'(1);
        sum_r   <= sum_r + SUM_W'(x);
        sq_r    <= sq_r + SQ_W'($unsigned(xsq));
      end else if (cmd == CMD_PUBLISH) begin
        count_r <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
      end

      // lag-sum pipeline control
      v1_r       <= issue;
      v2_r       <= v1_r;
      sum_done_r <= (cmd != CMD_SUM_START) && sum_drained;
      if (cmd == CMD_SUM_START) begin
        sum_act_r <= 1'b1;
      end else if (sum_drained) begin
        sum_act_r <= 1'b0;
      end

      // serial multiplier control
      mul_done_r <= !mul_start && mul_busy_r && (mul_cnt_r == STEP_W'(1));
      if (mul_start) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= STEP_W'(MUL_STEPS);
        mul_dst_r  <= cmd;
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r - STEP_W'(1);
        if (mul_cnt_r == STEP_W'(1)) begin
          mul_busy_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd == CMD_SUM_START) begin
      i_r   <= '0;
      acc_r <= '0;
    end else begin
      if (issue) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(p_r);
      end
    end
    p_r <= $signed(rd_a) * $signed(rd_b);

    if (mul_start) begin
      mul_a_r <= mul_a_in;
      mul_b_r <= mul_b_in;
      mul_p_r <= '0;
    end else if (mul_busy_r) begin
      mul_a_r <= mul_a_r <<< 1;
      mul_b_r <= mul_b_r >> 1;
      mul_p_r <= mul_p_nxt;
      if (mul_cnt_r == STEP_W'(1)) begin
        case (mul_dst_r)
          CMD_MUL_SSQ: ssq_r <= mul_p_nxt[SSQ_W-1:0];
          CMD_MUL_NQ:  nq_r  <= mul_p_nxt[NQ_W-1:0];
          CMD_MUL_NN:  nn_r  <= mul_p_nxt[NN_W-1:0];
          CMD_MUL_T1:  t1_r  <= mul_p_nxt;
          CMD_MUL_T2:  t2_r  <= mul_p_nxt;
          CMD_MUL_R1:  r1_r  <= mul_p_nxt;
          CMD_MUL_R2:  rhs_r <= mul_p_nxt;
          default:     ;
        endcase
      end
    end

    case (cmd)
      CMD_SETUP: begin
        var_r   <= nq_r - NQ_W'(ssq_r);
        limit_r <= (CNT_W'(max_lag_r) > n_m1) ? n_m1[LAG_W-1:0] : max_lag_r;
        k_r     <= '0;
      end
      CMD_NEXT_LAG: k_r   <= k_r + LAG_W'(1);
      CMD_DIFF:     num_r <= t1_r - t2_r;
      CMD_RES_ZERO, CMD_RES_FOUND, CMD_RES_CAP: begin
        cand_time_r <= (cand < min_lag_r) ? min_lag_r : cand;
        cand_cap_r  <= (cmd == CMD_RES_CAP);
        cand_zv_r   <= (cmd == CMD_RES_ZERO);
      end
      CMD_PUBLISH: begin
        out_time_r <= cand_time_r;
        out_cap_r  <= cand_cap_r;
        out_zv_r   <= cand_zv_r;
      end
      default: ;
    endcase
  end

  assign stat.mul_done = mul_done_r;
  assign stat.sum_done = sum_done_r;
  assign stat.var_zero = (var_r == '0);
  assign stat.less     = (num_r <<< 16) < rhs_r;
  assign stat.last_lag = (k_r == limit_r);

  assign res_time     = out_time_r;
  assign res_capped   = out_cap_r;
  assign res_zero_var = out_zv_r;

endmodule

@@ src/adt_ctrl.sv @@
// ----------------------------------------------------------------------------
// adt_ctrl: controller
// Sequences loading, the setup products, the lag search and the result.
// ----------------------------------------------------------------------------
module adt_ctrl
  import adt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_SSQ, ST_NQ, ST_NN, ST_MWAIT, ST_SETUP, ST_VCHK, ST_LAG,
    ST_SWAIT, ST_T1, ST_T2, ST_R1, ST_R2, ST_DIFF, ST_CMP, ST_OUT
  } state_t;

  state_t state_r, ret_r;
  logic   out_valid_r;
  logic   out_free;
  logic   publish;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign publish   = (state_r == ST_OUT) && out_free;

  always_comb begin
    case (state_r)
      ST_LOAD:  cmd = (in_valid) ? CMD_STORE : CMD_IDLE;
      ST_SSQ:   cmd = CMD_MUL_SSQ;
      ST_NQ:    cmd = CMD_MUL_NQ;
      ST_NN:    cmd = CMD_MUL_NN;
      ST_SETUP: cmd = CMD_SETUP;
      ST_VCHK:  cmd = stat.var_zero ? CMD_RES_ZERO : CMD_IDLE;
      ST_LAG:   cmd = CMD_SUM_START;
      ST_T1:    cmd = CMD_MUL_T1;
      ST_T2:    cmd = CMD_MUL_T2;
      ST_R1:    cmd = CMD_MUL_R1;
      ST_R2:    cmd = CMD_MUL_R2;
      ST_DIFF:  cmd = CMD_DIFF;
      ST_CMP:   cmd = stat.less ? CMD_RES_FOUND :
                      (stat.last_lag ? CMD_RES_CAP : CMD_NEXT_LAG);
      ST_OUT:   cmd = out_free ? CMD_PUBLISH : CMD_IDLE;
      default:  cmd = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ret_r       <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD:  if (in_valid && in_last) state_r <= ST_SSQ;
        ST_SSQ:   begin state_r <= ST_MWAIT; ret_r <= ST_NQ;    end
        ST_NQ:    begin state_r <= ST_MWAIT; ret_r <= ST_NN;    end
        ST_NN:    begin state_r <= ST_MWAIT; ret_r <= ST_SETUP; end
        ST_MWAIT: if (stat.mul_done) state_r <= ret_r;
        ST_SETUP: state_r <= ST_VCHK;
        ST_VCHK:  state_r <= stat.var_zero ? ST_OUT : ST_LAG;
        ST_LAG:   state_r <= ST_SWAIT;
        ST_SWAIT: if (stat.sum_done) state_r <= ST_T1;
        ST_T1:    begin state_r <= ST_MWAIT; ret_r <= ST_T2;   end
        ST_T2:    begin state_r <= ST_MWAIT; ret_r <= ST_R1;   end
        ST_R1:    begin state_r <= ST_MWAIT; ret_r <= ST_R2;   end
        ST_R2:    begin state_r <= ST_MWAIT; ret_r <= ST_DIFF; end
        ST_DIFF:  state_r <= ST_CMP;
        ST_CMP:   state_r <= (stat.less || stat.last_lag) ? ST_OUT : ST_LAG;
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_LOAD;
          end
        end
        default:  state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

@@ src/autocorrelation_decorrelation_time_core.sv @@
// ----------------------------------------------------------------------------
// autocorrelation_decorrelation_time_core: decorrelation-time search
// Loads a sample series, then finds the first lag whose normalised
// autocorrelation falls below the threshold, using exact integer compares.
// ----------------------------------------------------------------------------
// Loading: one sample transaction per cycle, no gaps needed.
// After the last sample: three setup products on the bit-serial multiplier, then per lag k
//   a lagged sum over (n - k) products, four products on the bit-serial multiplier
//   and a compare; the result is published from ST_OUT once the output is free.
// One series at a time: input stalls from the last sample until the result is out.
// Reset (rst_n low, synchronous) empties the series and loads the default registers.
module autocorrelation_decorrelation_time_core
  import adt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] sample
  input  logic                  in_tlast,   // last_sample
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [10:0] decorrel_time, rest zero
  output logic [1:0]            out_tuser,  // [0] lag_capped, [1] zero_variance
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [TIME_W-1:0] res_time;
  logic              res_capped, res_zero_var;

  // configuration is always taken; the user must write it only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  adt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  adt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .sample      (in_tdata[SAMPLE_W-1:0]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .res_time    (res_time),
    .res_capped  (res_capped),
    .res_zero_var(res_zero_var)
  );

  assign out_tdata = {{(16 - TIME_W){1'b0}}, res_time};
  assign out_tuser = {res_zero_var, res_capped};

  // the last sample of a series closes the input until the result is out
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after last sample");

  // a result only appears at the end of a search
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while loading");

  // multiplier and lag sum never finish together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mul_done |-> !stat.sum_done)
    else $error("multiplier and lag sum completed together");

endmodule

@@ test/tb_autocorrelation_decorrelation_time_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autocorrelation_decorrelation_time_core: decorrelation-time search test
// Streams sample series into the core under random source and sink stalls.
// An in-bench model of the lag search predicts each result. Every result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_autocorrelation_decorrelation_time_core;
  import adt_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] sample
  logic                  in_tlast;   // last_sample
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // [10:0] decorrel_time, rest zero
  logic [1:0]            out_tuser;  // [0] lag_capped, [1] zero_variance
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  typedef struct packed {
    logic [TIME_W-1:0] decorrel_time;
    logic              lag_capped;
    logic              zero_variance;
  } search_result_t;

  autocorrelation_decorrelation_time_core u_dut (.*);

  // model state
  int              series_buf [MAX_SAMPLES];
  int              series_len;
  longint          series_sum;
  longint          series_sumsq;
  logic [THR_W-1:0]  thr_reg;
  logic [LAG_W-1:0]  max_lag_reg;
  logic [TIME_W-1:0] min_lag_reg;
  search_result_t    pending_results[$];

  int  error_count;
  bit  src_burst;   // no gaps on the source while set
  bit  snk_burst;   // no stalls on the sink while set

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Exact lag search over the current series; queues one expected result.
  function automatic void predict_decorrelation();
    logic signed [127:0] n, s_sq, var_n, lagged, num, rhs, terms, thr;
    int unsigned limit;
    int unsigned res;
    bit found;
    search_result_t r;
    n      = series_len;
    s_sq   = 128'(series_sum) * 128'(series_sum);
    var_n  = 128'(series_sumsq) * n - s_sq;
    thr    = {112'd0, thr_reg};
    found  = 0;
    r      = '0;
    if (series_len == 0 || var_n == 0) begin
      r.zero_variance = 1'b1;
      res = 1;
    end else begin
      limit = max_lag_reg;
      if (limit > series_len - 1) limit = series_len - 1;
      for (int k = 0; k <= limit && !found; k++) begin
        lagged = 0;
        for (int i = 0; i < series_len - k; i++)
          lagged += 128'(longint'(series_buf[i]) * longint'(series_buf[i + k]));
        terms = series_len - k;
        num = (lagged * n * n - s_sq * terms) * 65536;
        rhs = var_n * terms * thr;
        if (num < rhs) begin
          found = 1;
          res = k + 1;
        end
      end
      if (!found) begin
        res = limit + 1;
        r.lag_capped = 1'b1;
      end
    end
    if (res < min_lag_reg) res = min_lag_reg;
    r.decorrel_time = res[TIME_W-1:0];
    pending_results.insert(pending_results.size(), r);
    series_len   = 0;
    series_sum   = 0;
    series_sumsq = 0;
  endfunction

  // Send one sample transaction; the model is updated on acceptance.
  task automatic send_sample(input logic [15:0] smp, input bit last);
    int gap;
    int x;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = smp;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    x = $signed(smp);
    if (series_len < MAX_SAMPLES) begin
      series_buf[series_len] = x;
      series_len++;
      series_sum   += x;
      series_sumsq += longint'(x) * longint'(x);
    end
    if (last) predict_decorrelation();
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
  endtask

  // Wait for the core to go idle, then write one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THR:    thr_reg     = val[THR_W-1:0];
      CFG_MAXLAG: max_lag_reg = val[LAG_W-1:0];
      CFG_MINLAG: min_lag_reg = val[TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_search(input int unsigned thr, input int unsigned mx,
                            input int unsigned mn);
    write_reg(CFG_THR, thr);
    write_reg(CFG_MAXLAG, mx);
    write_reg(CFG_MINLAG, mn);
  endtask

  // Random series; shape picks the kind of signal.
  task automatic send_series(input int len, input int shape);
    int walk;
    int v;
    walk = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: v = $urandom_range(0, 65535) - 32768;          // full-scale noise
        1: v = $urandom_range(0, 15) - 8;                 // small noise
        2: v = 1234;                                      // constant
        3: begin                                          // slow walk
          walk += $urandom_range(0, 2000) - 1000;
          if (walk > 32767) walk = 32767;
          if (walk < -32768) walk = -32768;
          v = walk;
        end
        default: v = ((i / 3) % 2) ? 32767 : -32768;      // square wave
      endcase
      send_sample(v[15:0], i == len - 1);
    end
  endtask

  // ---- test tasks ---------------------------------------------------------

  // Defaults: single sample, constant series, extremes, alternating signs, a ramp.
  task automatic test_directed();
    send_sample(16'h8000, 1'b1);               // one sample: zero variance
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);               // constant pair
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);               // alternating extremes
    for (int i = 0; i < 8; i++) send_sample(16'(i * 1000), i == 7);   // ramp
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
  endtask

  // Register extremes: threshold, lag cap and floor at both ends.
  task automatic test_register_extremes();
    set_search(0, 0, 0);
    send_series(6, 0);
    set_search(65535, 1023, 1024);
    send_series(10, 3);
    set_search(65535, 1023, 0);
    send_series(12, 0);
    send_series(1, 0);
    set_search(0, 1023, 0);
    send_series(9, 4);
    set_search(3277, 99, 5);
  endtask

  task automatic test_random();
    int items;
    int len;
    int sel;
    int series_no;
    items = 0;
    series_no = 0;
    while (items < 2000) begin
      if (series_no % 8 == 0) begin
        sel = $urandom_range(0, 3);
        set_search(sel == 0 ? 0 : sel == 1 ? 65535 : $urandom_range(0, 65535),
                   $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 40),
                   $urandom_range(0, 4) == 0 ? 1024 : $urandom_range(0, 12));
        src_burst = ($urandom_range(0, 3) == 0);
        snk_burst = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 5) == 0) wait (pending_results.size() == 0);
      sel = $urandom_range(0, 9);
      len = sel == 0 ? 1 : sel == 1 ? $urandom_range(30, 64) : $urandom_range(2, 30);
      send_series(len, $urandom_range(0, 4));
      items += len;
      series_no++;
    end
    src_burst = 0;
    snk_burst = 0;
  endtask

  // ---- sink: random stalls per result ------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = 1'b0;
      repeat (snk_burst ? 0 : $urandom_range(0, 9)) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ---- result checker -----------------------------------------------------
  always @(posedge clk) begin
    search_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction tdata=%h tuser=%b",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata !== {5'd0, exp_r.decorrel_time}) begin
          $display("%0t: decorrel_time expected %0d actual %0d (tdata %h)",
                   $time, exp_r.decorrel_time, out_tdata[10:0], out_tdata);
          error_count++;
        end
        if (out_tuser[0] !== exp_r.lag_capped) begin
          $display("%0t: lag_capped expected %b actual %b",
                   $time, exp_r.lag_capped, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== exp_r.zero_variance) begin
          $display("%0t: zero_variance expected %b actual %b",
                   $time, exp_r.zero_variance, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // ---- main sequence ------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THR;
    cfg_data = '0;
    error_count = 0;
    src_burst = 0;
    snk_burst = 0;
    series_len = 0;
    series_sum = 0;
    series_sumsq = 0;
    thr_reg = THR_RST;
    max_lag_reg = MAXLAG_RST;
    min_lag_reg = MINLAG_RST;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_random();

    wait (pending_results.size() == 0);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
